// ===== design/itp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and character helpers for the infix-to-postfix converter.
package itp_pkg;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNMATCHED = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef logic [7:0] symbol_type;

   // Binding strength of an operator character; all other characters rank lowest.
   function automatic logic [1:0] prec_of(input symbol_type c);
      logic [1:0] p;
      p = 2'd0;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         p = 2'd1;
      end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
         p = 2'd2;
      end
      return p;
   endfunction

   function automatic logic is_alnum(input symbol_type c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

// ===== design/infix_to_postfix_converter_top.sv =====
`timescale 1ns / 1ps
// Top level of the infix-to-postfix converter: sequencer, cached stack top and result register.
//
//   Channel   Direction  Ports                                                 Beat carries
//   req       in         req_valid, req_stall, req_in_symbol, req_end_of_expr  one character
//   rsp       out        rsp_valid, rsp_stall, rsp_out_symbol, rsp_has_symbol, one postfix
//                        rsp_status, rsp_last                                  symbol or marker
//
// A request beat is taken only while the sequencer is idle. An operand is held, sent out
// and closed in ST_SCAN; a push writes the stack and returns to ST_IDLE; an end beat or an
// error marker is sent from ST_SCAN; a ')' that finds its '(' goes through ST_LOAD, as
// dropping the '(' must refresh the top. Every symbol popped off the stack passes through
// ST_LOAD, because each pop must read the entry below through the single registered read port.
// Reset is synchronous and clears the sequencer, the stack count, the discard flag and
// the result valid flag; the stack memory itself is not cleared, as no entry is read
// before it has been written. A stalled result simply holds the sequencer at its next
// result; one result register decouples the channels.
module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  itp_pkg::symbol_type req_in_symbol,
   input  logic                req_end_of_expr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output itp_pkg::symbol_type rsp_out_symbol,
   output logic                rsp_has_symbol,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);
   import itp_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   // What the item being worked on asks of the stack.
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_END   = 3'd1;
   localparam logic [2:0] KIND_CLOSE = 3'd2;
   localparam logic [2:0] KIND_OPER  = 3'd3;
   localparam logic [2:0] KIND_OPEN  = 3'd4;

   logic [1:0]       state_ff, state_in;
   logic [2:0]       kind_ff, kind_in;
   logic [1:0]       prec_ff, prec_in;
   symbol_type       sym_ff, sym_in;
   symbol_type       top_ff, top_in;
   symbol_type       pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             discarding_ff, discarding_in;

   logic             rsp_valid_ff, rsp_valid_in;
   symbol_type       rsp_sym_ff, rsp_sym_in;
   logic             rsp_has_ff, rsp_has_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             wr_en, rd_en;
   logic [ADDR_W-1:0] rd_addr;
   symbol_type       rd_data;
   logic [CNT_W-1:0] count_m2;

   logic             slot_free, nonempty, full, top_is_open, pop_cond, tail_result;
   logic             emit, emit_has, emit_last;
   symbol_type       emit_sym;
   logic [1:0]       emit_status;

   itp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (sym_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign nonempty    = (count_ff != '0);
   assign full        = (count_ff >= DEPTH_CNT);
   assign top_is_open = (top_ff == CHAR_OPEN);
   assign count_m2    = count_ff - CNT_W'(2);
   assign rd_addr     = count_m2[ADDR_W-1:0];

   // Whether the symbol on top must be popped next, and whether the item closes with
   // a marker of its own once popping has stopped.
   always_comb begin
      pop_cond    = 1'b0;
      tail_result = 1'b0;
      case (kind_ff)
         KIND_END: begin
            pop_cond    = nonempty;
            tail_result = 1'b1;
         end
         KIND_CLOSE: begin
            pop_cond    = nonempty && !top_is_open;
            tail_result = !nonempty;
         end
         KIND_OPER: begin
            pop_cond    = nonempty && !top_is_open && (prec_of(top_ff) >= prec_ff);
            tail_result = full;
         end
         KIND_OPEN: begin
            tail_result = full;
         end
         default: begin
            pop_cond    = 1'b0;
            tail_result = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      prec_in       = prec_ff;
      sym_in        = sym_ff;
      top_in        = top_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      discarding_in = discarding_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      emit          = 1'b0;
      emit_sym      = '0;
      emit_has      = 1'b0;
      emit_status   = STATUS_OK;
      emit_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sym_in  = req_in_symbol;
               prec_in = prec_of(req_in_symbol);
               if (req_end_of_expr) begin
                  // A discarded expression is not flushed, only closed.
                  kind_in  = KIND_END;
                  state_in = ST_SCAN;
                  if (discarding_ff) begin
                     count_in = '0;
                  end
               end else if (!discarding_ff) begin
                  state_in = ST_SCAN;
                  if (is_alnum(req_in_symbol)) begin
                     pend_in       = req_in_symbol;
                     pend_valid_in = 1'b1;
                     kind_in       = KIND_NONE;
                  end else if (req_in_symbol == CHAR_OPEN) begin
                     kind_in = KIND_OPEN;
                  end else if (req_in_symbol == CHAR_CLOSE) begin
                     kind_in = KIND_CLOSE;
                  end else begin
                     kind_in = KIND_OPER;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (pend_valid_ff) begin
               // The held symbol is final when no pop and no marker follow it.
               if (slot_free) begin
                  emit          = 1'b1;
                  emit_sym      = pend_ff;
                  emit_has      = 1'b1;
                  emit_last     = !(pop_cond || tail_result);
                  pend_valid_in = 1'b0;
               end
            end else if (pop_cond) begin
               pend_in       = top_ff;
               pend_valid_in = 1'b1;
               count_in      = count_ff - CNT_W'(1);
               rd_en         = (count_ff >= CNT_W'(2));
               state_in      = ST_LOAD;
            end else begin
               case (kind_ff)
                  KIND_END: begin
                     if (slot_free) begin
                        emit          = 1'b1;
                        emit_last     = 1'b1;
                        count_in      = '0;
                        discarding_in = 1'b0;
                        state_in      = ST_IDLE;
                     end
                  end
                  KIND_CLOSE: begin
                     if (!nonempty) begin
                        if (slot_free) begin
                           emit          = 1'b1;
                           emit_status   = STATUS_UNMATCHED;
                           emit_last     = 1'b1;
                           discarding_in = 1'b1;
                           state_in      = ST_IDLE;
                        end
                     end else begin
                        // Drop the matching opening parenthesis and refresh the top.
                        count_in = count_ff - CNT_W'(1);
                        rd_en    = (count_ff >= CNT_W'(2));
                        kind_in  = KIND_NONE;
                        state_in = ST_LOAD;
                     end
                  end
                  KIND_OPER, KIND_OPEN: begin
                     if (full) begin
                        if (slot_free) begin
                           emit          = 1'b1;
                           emit_status   = STATUS_OVERFLOW;
                           emit_last     = 1'b1;
                           discarding_in = 1'b1;
                           state_in      = ST_IDLE;
                        end
                     end else begin
                        wr_en    = 1'b1;
                        top_in   = sym_ff;
                        count_in = count_ff + CNT_W'(1);
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            top_in   = rd_data;
            state_in = ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sym_in    = rsp_sym_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sym_in    = emit_sym;
         rsp_has_in    = emit_has;
         rsp_status_in = emit_status;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         discarding_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         discarding_ff <= discarding_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      prec_ff       <= prec_in;
      sym_ff        <= sym_in;
      top_ff        <= top_in;
      pend_ff       <= pend_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = rsp_sym_ff;
   assign rsp_has_symbol = rsp_has_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== design/itp_stack.sv =====
`timescale 1ns / 1ps
// Operator stack storage: one write port and one registered read port.
module itp_stack #(
   parameter int STACK_DEPTH = 32,
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  itp_pkg::symbol_type     wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output itp_pkg::symbol_type     rd_data
);
   import itp_pkg::*;

   symbol_type mem [STACK_DEPTH];
   symbol_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/infix_to_postfix_converter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the infix-to-postfix converter, with its own shunting-yard predictor.
module infix_to_postfix_converter_top_tb;
   import itp_pkg::*;

   localparam int STACK_DEPTH    = 32;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 150;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      symbol_type sym;
      logic       eoe;
   } infix_char_type;

   typedef struct packed {
      symbol_type sym;
      logic       has;
      logic [1:0] status;
      logic       last;
   } postfix_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   symbol_type req_in_symbol = '0;
   logic       req_end_of_expr = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   symbol_type rsp_out_symbol;
   logic       rsp_has_symbol;
   logic [1:0] rsp_status;
   logic       rsp_last;

   infix_char_type pending_chars[$];
   postfix_type    expected_postfix[$];
   postfix_type    beat_postfix[$];

   // Predictor state: operator stack, its fill level and the drop-until-end flag.
   symbol_type  op_stack_model [STACK_DEPTH];
   int          op_depth = 0;
   bit          dropping = 1'b0;

   int error_count = 0;
   int beats_taken = 0;
   int idle_cycles = 0;

   infix_to_postfix_converter_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_symbol  (req_in_symbol),
      .req_end_of_expr(req_end_of_expr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_has_symbol (rsp_has_symbol),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [1:0] binding_rank(input symbol_type c);
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         return 2'd1;
      end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
         return 2'd2;
      end
      return 2'd0;
   endfunction

   function automatic bit is_operand(input symbol_type c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   task automatic emit_marker(input logic [1:0] status);
      postfix_type r;
      r = '0;
      r.status = status;
      beat_postfix.push_back(r);
   endtask

   task automatic pop_operator();
      postfix_type r;
      op_depth--;
      r = '0;
      r.sym = op_stack_model[op_depth];
      r.has = 1'b1;
      r.status = STATUS_OK;
      beat_postfix.push_back(r);
   endtask

   task automatic push_operator(input symbol_type c);
      if (op_depth >= STACK_DEPTH) begin
         dropping = 1'b1;
         emit_marker(STATUS_OVERFLOW);
      end else begin
         op_stack_model[op_depth] = c;
         op_depth++;
      end
   endtask

   // Works out the postfix beats that one accepted infix beat causes.
   task automatic shunt_char(input symbol_type c, input logic eoe);
      postfix_type r;
      logic [1:0] rank;
      beat_postfix.delete();
      if (eoe) begin
         if (!dropping) begin
            while (op_depth > 0) pop_operator();
         end
         emit_marker(STATUS_OK);
         op_depth = 0;
         dropping = 1'b0;
      end else if (dropping) begin
         // Everything up to the end beat is swallowed after an error.
      end else if (is_operand(c)) begin
         r = '0;
         r.sym = c;
         r.has = 1'b1;
         r.status = STATUS_OK;
         beat_postfix.push_back(r);
      end else if (c == CHAR_OPEN) begin
         push_operator(c);
      end else if (c == CHAR_CLOSE) begin
         while (op_depth > 0 && op_stack_model[op_depth - 1] != CHAR_OPEN) pop_operator();
         if (op_depth == 0) begin
            emit_marker(STATUS_UNMATCHED);
            dropping = 1'b1;
         end else begin
            op_depth--;
         end
      end else begin
         rank = binding_rank(c);
         while (op_depth > 0 && op_stack_model[op_depth - 1] != CHAR_OPEN &&
                binding_rank(op_stack_model[op_depth - 1]) >= rank) pop_operator();
         push_operator(c);
      end
      if (beat_postfix.size() > 0) begin
         r = beat_postfix[beat_postfix.size() - 1];
         r.last = 1'b1;
         beat_postfix[beat_postfix.size() - 1] = r;
      end
      foreach (beat_postfix[i]) expected_postfix.push_back(beat_postfix[i]);
   endtask

   // Mostly short idles, now and then a long one; none at all in burst mode.
   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic queue_char(input symbol_type c);
      infix_char_type item;
      item.sym = c;
      item.eoe = 1'b0;
      pending_chars.push_back(item);
   endtask

   task automatic queue_end(input symbol_type ignored);
      infix_char_type item;
      item.sym = ignored;
      item.eoe = 1'b1;
      pending_chars.push_back(item);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(symbol_type'(s[i]));
   endtask

   function automatic symbol_type random_operand();
      case ($urandom_range(0, 2))
         0:       return symbol_type'(8'h30 + $urandom_range(0, 9));
         1:       return symbol_type'(8'h41 + $urandom_range(0, 25));
         default: return symbol_type'(8'h61 + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic symbol_type random_operator();
      symbol_type c;
      case ($urandom_range(0, 9))
         0, 1:    c = CHAR_PLUS;
         2, 3:    c = CHAR_MINUS;
         4, 5:    c = CHAR_STAR;
         6, 7:    c = CHAR_SLASH;
         default: begin
            c = symbol_type'($urandom_range(0, 255));
            while (is_operand(c) || c == CHAR_OPEN || c == CHAR_CLOSE) begin
               c = symbol_type'($urandom_range(0, 255));
            end
         end
      endcase
      return c;
   endfunction

   // A random expression; when broken it may gain a stray ')' and may keep open parentheses.
   task automatic queue_expression(input int operands, input bit broken);
      int depth;
      depth = 0;
      for (int i = 0; i < operands; i++) begin
         while ($urandom_range(0, 3) == 0) begin
            queue_char(CHAR_OPEN);
            depth++;
         end
         queue_char(random_operand());
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            queue_char(CHAR_CLOSE);
            depth--;
         end
         if (i < operands - 1) queue_char(random_operator());
      end
      if (!broken || $urandom_range(0, 1) == 0) begin
         repeat (depth) queue_char(CHAR_CLOSE);
      end
      if (broken && $urandom_range(0, 1) == 0) begin
         queue_char(CHAR_CLOSE);
         queue_char(random_operand());
         queue_char(random_operator());
         queue_char(random_operand());
      end
      queue_end(symbol_type'($urandom_range(0, 255)));
   endtask

   // Alternating '(' and operators stack up without popping, so the stack fills quickly.
   task automatic queue_deep(input int pushes);
      for (int i = 0; i < pushes; i++) begin
         queue_char((i % 2 == 0) ? CHAR_OPEN : random_operator());
      end
      queue_char(random_operand());
      if ($urandom_range(0, 1) == 0) queue_char(CHAR_CLOSE);
      queue_end(symbol_type'($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin : request_driver
      infix_char_type item;
      static int req_gap = 0;
      static bit req_burst = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            shunt_char(req_in_symbol, req_end_of_expr);
            beats_taken <= beats_taken + 1;
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
               item = pending_chars.pop_front();
               req_valid <= 1'b1;
               req_in_symbol <= item.sym;
               req_end_of_expr <= item.eoe;
               req_gap = pick_gap(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      postfix_type got;
      postfix_type want;
      logic next_stall;
      static int stall_left = 0;
      static int holdoff = 0;
      static int next_holdoff_at = 30;
      static bit rsp_burst = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.sym = rsp_out_symbol;
            got.has = rsp_has_symbol;
            got.status = rsp_status;
            got.last = rsp_last;
            if (expected_postfix.size() == 0) begin
               $display("%0t: unexpected result beat sym=%h has=%b status=%0d last=%b",
                        $time, got.sym, got.has, got.status, got.last);
               error_count++;
            end else begin
               want = expected_postfix.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected sym=%h has=%b status=%0d last=%b,",
                           $time, want.sym, want.has, want.status, want.last,
                           " actual sym=%h has=%b status=%0d last=%b",
                           got.sym, got.has, got.status, got.last);
                  error_count++;
               end
            end
         end
         // A long hold-off now and then lets the block fill up and stall its input.
         if ($urandom_range(0, 149) == 0) rsp_burst = !rsp_burst;
         if (holdoff > 0) begin
            holdoff--;
            next_stall = 1'b1;
         end else if (beats_taken >= next_holdoff_at) begin
            holdoff = HOLDOFF_CYCLES;
            next_holdoff_at += 120;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else begin
            stall_left = pick_gap(rsp_burst);
            next_stall = (stall_left > 0);
         end
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int target;
      int kind;
      // Precedence, parentheses, alphanumeric boundaries, an unmatched ')', an unclosed '(',
      // an empty expression, lone operators and high or zero codes that rank as weakest operators.
      queue_text("0+A*z");
      queue_end(8'h00);
      queue_text("(Z-9)/a");
      queue_end(8'h55);
      queue_text(")x");
      queue_end(8'hAA);
      queue_char(8'h00);
      queue_char(8'hFF);
      queue_char(8'h80);
      queue_char(CHAR_OPEN);
      queue_end(8'hFF);
      queue_end(8'hFF);
      queue_text("+*-");
      queue_end(8'h7F);
      target = pending_chars.size() + 190;
      queue_deep(STACK_DEPTH);
      queue_deep(STACK_DEPTH + 2);
      while (pending_chars.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 68) begin
            queue_expression($urandom_range(1, 6), 1'b0);
         end else if (kind < 82) begin
            queue_expression($urandom_range(1, 5), 1'b1);
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 6)) queue_char(symbol_type'($urandom_range(0, 255)));
            queue_end(symbol_type'($urandom_range(0, 255)));
         end else begin
            queue_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_valid || expected_postfix.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
